// File: src/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Widths, depth and status codes shared by the stack and its interfaces.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ENTRY_W     = 34;

	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [CNT_W-1:0]          count_t;
	typedef logic [1:0]                status_t;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	localparam data_t  INT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t  EMPTY_TOP  = {DATA_W{1'b1}};
	localparam count_t FULL_COUNT = CNT_W'(STACK_DEPTH);

endpackage

// File: src/mts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack channels
// Command channel and result channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------
interface mts_cmd_if
	import mts_pkg::*;
	();
	logic  valid;
	logic  ready;
	logic  command;
	data_t value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface mts_rsp_if
	import mts_pkg::*;
	();
	logic    valid;
	logic    ready;
	data_t   top_value;
	data_t   min_value;
	logic    is_empty;
	status_t status;

	modport source (output valid, output top_value, output min_value, output is_empty,
		output status, input ready);
	modport sink (input valid, input top_value, input min_value, input is_empty,
		input status, output ready);
endinterface

// File: src/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack
// A push completes in the idle state; a pop waits in the pop state on the read
// of the new top entry from the entry memory, unless the stack is empty and it
// reports underflow. The result beat is registered. Reset empties the stack
// and sets the minimum to the largest positive value; memory is not cleared.
// ----------------------------------------------------------------------------
module min_tracking_stack
	import mts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	mts_cmd_if.sink   req,
	mts_rsp_if.source rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_POP  = 1'b1;

	logic   state_q;
	count_t count_q;
	data_t  min_q;
	entry_t top_q;

	logic    out_valid_q;
	data_t   out_top_q;
	data_t   out_min_q;
	logic    out_empty_q;
	status_t out_status_q;

	logic   accept;
	logic   out_free;
	logic   wr_en;
	addr_t  wr_addr;
	entry_t wr_data;
	logic   rd_en;
	addr_t  rd_addr;
	entry_t rd_data;

	entry_t value_ext;
	entry_t min_ext;
	entry_t push_entry;
	data_t  push_min;
	logic   push_lower;
	logic   top_encoded;
	data_t  top_decoded;
	entry_t restore_min;
	data_t  pop_min;
	count_t pop_count;
	logic   rd_encoded;
	data_t  rd_decoded;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign value_ext  = ENTRY_W'(req.value);
	assign min_ext    = ENTRY_W'(min_q);
	assign push_lower = (count_q == '0) || (req.value < min_q);
	assign push_entry = ((count_q == '0) || !push_lower) ? value_ext
		: (value_ext <<< 1) - min_ext;
	assign push_min   = push_lower ? req.value : min_q;

	assign top_encoded = top_q < min_ext;
	assign top_decoded = top_encoded ? min_q : top_q[DATA_W-1:0];
	assign restore_min = (min_ext <<< 1) - top_q;
	assign pop_min     = top_encoded ? restore_min[DATA_W-1:0] : min_q;
	assign pop_count   = count_q - count_t'(1);

	assign rd_encoded = rd_data < min_ext;
	assign rd_decoded = rd_encoded ? min_q : rd_data[DATA_W-1:0];

	assign wr_en   = accept && (req.command == CMD_PUSH) && (count_q != FULL_COUNT);
	assign wr_addr = count_q[ADDR_W-1:0];
	assign wr_data = push_entry;
	assign rd_en   = accept && (req.command == CMD_POP) && (count_q != '0);
	assign rd_addr = pop_count[ADDR_W-1:0] - addr_t'(1);

	mts_entry_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			min_q       <= INT_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == CMD_PUSH) begin
							out_valid_q <= 1'b1;
							if (count_q != FULL_COUNT) begin
								count_q <= count_q + count_t'(1);
								min_q   <= push_min;
							end
						end else if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							count_q <= pop_count;
							min_q   <= pop_min;
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command == CMD_PUSH) begin
						out_min_q   <= count_q != FULL_COUNT ? push_min : min_q;
						out_empty_q <= 1'b0;
						if (count_q != FULL_COUNT) begin
							top_q        <= push_entry;
							out_top_q    <= req.value;
							out_status_q <= ST_OK;
						end else begin
							out_top_q    <= top_decoded;
							out_status_q <= ST_OVERFLOW;
						end
					end else begin
						out_top_q    <= EMPTY_TOP;
						out_min_q    <= min_q;
						out_empty_q  <= 1'b1;
						out_status_q <= ST_UNDERFLOW;
					end
				end
			end
			S_POP: begin
				out_min_q    <= min_q;
				out_status_q <= ST_OK;
				if (count_q == '0) begin
					out_top_q   <= EMPTY_TOP;
					out_empty_q <= 1'b1;
				end else begin
					top_q       <= rd_data;
					out_top_q   <= rd_decoded;
					out_empty_q <= 1'b0;
				end
			end
			default: begin
				out_status_q <= ST_OK;
			end
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.top_value = out_top_q;
	assign rsp.min_value = out_min_q;
	assign rsp.is_empty  = out_empty_q;
	assign rsp.status    = out_status_q;

endmodule

// File: src/mts_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack entry memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mts_entry_ram
	import mts_pkg::*;
(
	input  logic   clk,
	input  logic   wr_en,
	input  addr_t  wr_addr,
	input  entry_t wr_data,
	input  logic   rd_en,
	input  addr_t  rd_addr,
	output entry_t rd_data
);

	entry_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
